@@ sv/sfepv_pkg.sv @@
// Package: phase codes, request/action/status codes, config indices, reset defaults, commands and result type.
`timescale 1ns / 1ps
`default_nettype none

package sfepv_pkg;

  typedef enum logic [12:0] {
    PH_IDLE    = 13'h0001,
    PH_ID      = 13'h0002,
    PH_WREN_E  = 13'h0004,
    PH_BE      = 13'h0008,
    PH_ESR     = 13'h0010,
    PH_EWAIT   = 13'h0020,
    PH_WREN_P0 = 13'h0040,
    PH_RSR0    = 13'h0080,
    PH_PG_WREN = 13'h0100,
    PH_PG      = 13'h0200,
    PH_PSR     = 13'h0400,
    PH_PWAIT   = 13'h0800,
    PH_VF      = 13'h1000
  } phase_t;

  localparam logic [1:0] REQ_START     = 2'd0;
  localparam logic [1:0] REQ_XFER_DONE = 2'd1;
  localparam logic [1:0] REQ_WAIT_DONE = 2'd2;

  localparam logic [1:0] ACT_XCHG = 2'd0;
  localparam logic [1:0] ACT_WAIT = 2'd1;
  localparam logic [1:0] ACT_DONE = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_ERASE_TO = 2'd1;
  localparam logic [1:0] STS_MISMATCH = 2'd2;

  localparam logic [1:0] CFG_IMAGE_PAGES = 2'd0;
  localparam logic [1:0] CFG_VERIFY_EN   = 2'd1;
  localparam logic [1:0] CFG_ERASE_LIMIT = 2'd2;
  localparam logic [1:0] CFG_PAGE_LIMIT  = 2'd3;

  localparam logic [7:0] CMD_RDID = 8'h9F;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_BE   = 8'hC7;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] DUMMY    = 8'h00;

  localparam logic [12:0] RST_IMAGE_PAGES = 13'd1;
  localparam logic        RST_VERIFY_EN   = 1'b1;
  localparam logic [7:0]  RST_ERASE_LIMIT = 8'd20;
  localparam logic [7:0]  RST_PAGE_LIMIT  = 8'd100;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] mosi_byte;
    logic       release_select;
    logic       wait_long;
    logic       want_image;
    logic [1:0] status_code;
  } result_t;

endpackage

`default_nettype wire

@@ sv/spi_flash_erase_program_verify_unit.sv @@
// Top level: SPI NOR flash erase, page program and verify sequencer.
//
// Input channel (in_valid/in_ready) carries one request per transaction:
// start, SPI byte exchanged (with miso_byte and, when asked, image_byte),
// or wait elapsed. Each accepted request yields zero or one result on the
// output channel (out_valid/out_ready): exchange a byte, wait, or done with
// a status. Requests that do not fit the current phase give no result.
// The step logic sits between the request and a single result register:
// a result is registered in the cycle after its request is accepted,
// and one request is taken per cycle while in_ready is high: whenever
// the result register is empty or is being drained. A stalled receiver
// holds the pending result and blocks further requests until it is taken.
// Registers are written through cfg_write_enable/cfg_index/cfg_data and
// take effect at once. Synchronous reset returns the sequencer to idle and
// loads the register defaults (1 page, verify on, limits 20 and 100).
`timescale 1ns / 1ps
`default_nettype none

module spi_flash_erase_program_verify_unit #(
  parameter int PAGE_SIZE = 256,
  parameter int MAX_PAGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  miso_byte,
  input  wire logic [7:0]  image_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       action,
  output logic [7:0]       mosi_byte,
  output logic             release_select,
  output logic             wait_long,
  output logic             want_image,
  output logic [1:0]       status_code
);

  localparam int BI_W   = $clog2(PAGE_SIZE + 4);
  localparam int PN_W   = $clog2(MAX_PAGES + 1);
  localparam int CMP_W  = (PN_W > 13) ? PN_W : 13;

  localparam logic [BI_W-1:0]  BI_ONE  = BI_W'(1);
  localparam logic [BI_W-1:0]  BI_TWO  = BI_W'(2);
  localparam logic [BI_W-1:0]  BI_ADDR = BI_W'(3);
  localparam logic [BI_W-1:0]  BI_ID4  = BI_W'(4);
  localparam logic [BI_W-1:0]  BI_ID5  = BI_W'(5);
  localparam logic [BI_W-1:0]  BI_LAST = BI_W'(3 + PAGE_SIZE - 1);
  localparam logic [BI_W-1:0]  BI_END  = BI_W'(3 + PAGE_SIZE);
  localparam logic [CMP_W-1:0] MAXP    = CMP_W'(MAX_PAGES);

  // configuration
  logic [12:0] image_pages;
  logic        verify_enable;
  logic [7:0]  erase_poll_limit;
  logic [7:0]  page_poll_limit;

  // sequencer state
  sfepv_pkg::phase_t phase, phase_next;
  logic [BI_W-1:0]   byte_index, byte_index_next;
  logic [PN_W-1:0]   page_number, page_number_next;
  logic [7:0]        poll_count, poll_count_next;
  logic              mismatch_seen, mismatch_seen_next;

  sfepv_pkg::result_t res, out_res;
  logic               has_res;
  logic               accept;

  logic [CMP_W-1:0]  pages_eff;
  logic [23:0]       page_addr;
  logic [7:0]        addr_sel;
  logic              go_page, go_verify, mism;
  logic [PN_W-1:0]   pn_cand;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_pages      <= sfepv_pkg::RST_IMAGE_PAGES;
      verify_enable    <= sfepv_pkg::RST_VERIFY_EN;
      erase_poll_limit <= sfepv_pkg::RST_ERASE_LIMIT;
      page_poll_limit  <= sfepv_pkg::RST_PAGE_LIMIT;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        sfepv_pkg::CFG_IMAGE_PAGES: image_pages      <= cfg_data;
        sfepv_pkg::CFG_VERIFY_EN:   verify_enable    <= cfg_data[0];
        sfepv_pkg::CFG_ERASE_LIMIT: erase_poll_limit <= cfg_data[7:0];
        sfepv_pkg::CFG_PAGE_LIMIT:  page_poll_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign pages_eff = (CMP_W'(image_pages) > MAXP) ? MAXP : CMP_W'(image_pages);
  // page address wraps to 24 bits
  assign page_addr = 24'(page_number) * 24'(PAGE_SIZE);

  always_comb begin
    case (byte_index[1:0])
      2'd0:    addr_sel = page_addr[23:16];
      2'd1:    addr_sel = page_addr[15:8];
      2'd2:    addr_sel = page_addr[7:0];
      default: addr_sel = 8'h00;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    page_number_next   = page_number;
    poll_count_next    = poll_count;
    mismatch_seen_next = mismatch_seen;
    has_res            = 1'b0;
    res                = '0;
    go_page            = 1'b0;
    go_verify          = 1'b0;
    pn_cand            = page_number + PN_W'(1);
    mism               = mismatch_seen;

    if (req_type == sfepv_pkg::REQ_START) begin
      if (phase == sfepv_pkg::PH_IDLE) begin
        phase_next         = sfepv_pkg::PH_ID;
        byte_index_next    = BI_ONE;
        page_number_next   = '0;
        poll_count_next    = '0;
        mismatch_seen_next = 1'b0;
        has_res            = 1'b1;
        res.mosi_byte      = sfepv_pkg::CMD_RDID;
      end
    end else if (req_type == sfepv_pkg::REQ_WAIT_DONE) begin
      if (phase == sfepv_pkg::PH_EWAIT) begin
        phase_next      = sfepv_pkg::PH_ESR;
        byte_index_next = BI_ONE;
        has_res         = 1'b1;
        res.mosi_byte   = sfepv_pkg::CMD_RDSR;
      end else if (phase == sfepv_pkg::PH_PWAIT) begin
        if (poll_count >= page_poll_limit) begin
          go_page = 1'b1;
        end else begin
          phase_next      = sfepv_pkg::PH_PSR;
          byte_index_next = BI_ONE;
          has_res         = 1'b1;
          res.mosi_byte   = sfepv_pkg::CMD_RDSR;
        end
      end
    end else if (req_type == sfepv_pkg::REQ_XFER_DONE) begin
      case (phase)
        sfepv_pkg::PH_ID: begin
          has_res = 1'b1;
          if (byte_index < BI_ID5) begin
            res.mosi_byte      = sfepv_pkg::DUMMY;
            res.release_select = (byte_index == BI_ID4);
            byte_index_next    = byte_index + BI_ONE;
          end else begin
            phase_next         = sfepv_pkg::PH_WREN_E;
            res.mosi_byte      = sfepv_pkg::CMD_WREN;
            res.release_select = 1'b1;
          end
        end
        sfepv_pkg::PH_WREN_E: begin
          phase_next         = sfepv_pkg::PH_BE;
          has_res            = 1'b1;
          res.mosi_byte      = sfepv_pkg::CMD_BE;
          res.release_select = 1'b1;
        end
        sfepv_pkg::PH_BE: begin
          poll_count_next = '0;
          phase_next      = sfepv_pkg::PH_ESR;
          byte_index_next = BI_ONE;
          has_res         = 1'b1;
          res.mosi_byte   = sfepv_pkg::CMD_RDSR;
        end
        sfepv_pkg::PH_ESR: begin
          has_res = 1'b1;
          if (byte_index == BI_ONE) begin
            byte_index_next    = BI_TWO;
            res.mosi_byte      = sfepv_pkg::DUMMY;
            res.release_select = 1'b1;
          end else if (miso_byte[0]) begin
            if (poll_count >= erase_poll_limit) begin
              phase_next      = sfepv_pkg::PH_IDLE;
              res.action      = sfepv_pkg::ACT_DONE;
              res.status_code = sfepv_pkg::STS_ERASE_TO;
            end else begin
              poll_count_next = poll_count + 8'd1;
              phase_next      = sfepv_pkg::PH_EWAIT;
              res.action      = sfepv_pkg::ACT_WAIT;
              res.wait_long   = 1'b1;
            end
          end else begin
            phase_next         = sfepv_pkg::PH_WREN_P0;
            res.mosi_byte      = sfepv_pkg::CMD_WREN;
            res.release_select = 1'b1;
          end
        end
        sfepv_pkg::PH_WREN_P0: begin
          phase_next      = sfepv_pkg::PH_RSR0;
          byte_index_next = BI_ONE;
          has_res         = 1'b1;
          res.mosi_byte   = sfepv_pkg::CMD_RDSR;
        end
        sfepv_pkg::PH_RSR0: begin
          if (byte_index == BI_ONE) begin
            byte_index_next    = BI_TWO;
            has_res            = 1'b1;
            res.mosi_byte      = sfepv_pkg::DUMMY;
            res.release_select = 1'b1;
          end else begin
            pn_cand = '0;
            go_page = 1'b1;
          end
        end
        sfepv_pkg::PH_PG_WREN: begin
          phase_next      = sfepv_pkg::PH_PG;
          byte_index_next = '0;
          has_res         = 1'b1;
          res.mosi_byte   = sfepv_pkg::CMD_PP;
        end
        sfepv_pkg::PH_PG: begin
          if (byte_index < BI_ADDR) begin
            has_res         = 1'b1;
            res.mosi_byte   = addr_sel;
            res.want_image  = (byte_index == BI_TWO);
            byte_index_next = byte_index + BI_ONE;
          end else if (byte_index < BI_END) begin
            has_res            = 1'b1;
            res.mosi_byte      = image_byte;
            res.release_select = (byte_index == BI_LAST);
            res.want_image     = (byte_index < BI_LAST);
            byte_index_next    = byte_index + BI_ONE;
          end else begin
            poll_count_next = '0;
            if (page_poll_limit == 8'd0) begin
              go_page = 1'b1;
            end else begin
              phase_next      = sfepv_pkg::PH_PSR;
              byte_index_next = BI_ONE;
              has_res         = 1'b1;
              res.mosi_byte   = sfepv_pkg::CMD_RDSR;
            end
          end
        end
        sfepv_pkg::PH_PSR: begin
          if (byte_index == BI_ONE) begin
            byte_index_next    = BI_TWO;
            has_res            = 1'b1;
            res.mosi_byte      = sfepv_pkg::DUMMY;
            res.release_select = 1'b1;
          end else if (miso_byte[0]) begin
            poll_count_next = poll_count + 8'd1;
            phase_next      = sfepv_pkg::PH_PWAIT;
            has_res         = 1'b1;
            res.action      = sfepv_pkg::ACT_WAIT;
          end else begin
            go_page = 1'b1;
          end
        end
        sfepv_pkg::PH_VF: begin
          if (byte_index < BI_ADDR) begin
            has_res         = 1'b1;
            res.mosi_byte   = addr_sel;
            byte_index_next = byte_index + BI_ONE;
          end else begin
            if (byte_index > BI_ADDR && miso_byte != image_byte) begin
              mism = 1'b1;
            end
            mismatch_seen_next = mism;
            if (byte_index < BI_END) begin
              has_res            = 1'b1;
              res.mosi_byte      = sfepv_pkg::DUMMY;
              res.release_select = (byte_index == BI_LAST);
              res.want_image     = 1'b1;
              byte_index_next    = byte_index + BI_ONE;
            end else if (mism) begin
              phase_next      = sfepv_pkg::PH_IDLE;
              has_res         = 1'b1;
              res.action      = sfepv_pkg::ACT_DONE;
              res.status_code = sfepv_pkg::STS_MISMATCH;
            end else begin
              page_number_next = pn_cand;
              go_verify        = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // move to a page, or past the last one
    if (go_page) begin
      page_number_next = pn_cand;
      if (CMP_W'(pn_cand) >= pages_eff) begin
        if (verify_enable) begin
          page_number_next = '0;
          go_verify        = 1'b1;
        end else begin
          phase_next = sfepv_pkg::PH_IDLE;
          has_res    = 1'b1;
          res.action = sfepv_pkg::ACT_DONE;
        end
      end else begin
        phase_next         = sfepv_pkg::PH_PG_WREN;
        has_res            = 1'b1;
        res.mosi_byte      = sfepv_pkg::CMD_WREN;
        res.release_select = 1'b1;
      end
    end

    if (go_verify) begin
      has_res = 1'b1;
      if (CMP_W'(page_number_next) >= pages_eff) begin
        phase_next = sfepv_pkg::PH_IDLE;
        res.action = sfepv_pkg::ACT_DONE;
      end else begin
        phase_next         = sfepv_pkg::PH_VF;
        byte_index_next    = '0;
        mismatch_seen_next = 1'b0;
        res.mosi_byte      = sfepv_pkg::CMD_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfepv_pkg::PH_IDLE;
      byte_index    <= '0;
      page_number   <= '0;
      poll_count    <= '0;
      mismatch_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        byte_index    <= byte_index_next;
        page_number   <= page_number_next;
        poll_count    <= poll_count_next;
        mismatch_seen <= mismatch_seen_next;
        out_valid     <= has_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      out_res <= res;
    end
  end

  assign action         = out_res.action;
  assign mosi_byte      = out_res.mosi_byte;
  assign release_select = out_res.release_select;
  assign wait_long      = out_res.wait_long;
  assign want_image     = out_res.want_image;
  assign status_code    = out_res.status_code;

endmodule

`default_nettype wire

@@ sv/sfepv_checker.sv @@
// Port-level checker for the sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sfepv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] action,
  input wire logic [7:0] mosi_byte,
  input wire logic       release_select,
  input wire logic       wait_long,
  input wire logic       want_image,
  input wire logic [1:0] status_code
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(mosi_byte)
      && $stable(release_select) && $stable(want_image) && $stable(status_code))
    else $error("stalled result changed");

  // empty result register never blocks requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  a_xchg_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != sfepv_pkg::ACT_XCHG |-> mosi_byte == 8'h00 && !release_select)
    else $error("byte fields set on non-exchange result");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != sfepv_pkg::ACT_DONE |-> status_code == sfepv_pkg::STS_OK)
    else $error("status set on non-finish result");

  a_wait_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != sfepv_pkg::ACT_WAIT |-> !wait_long)
    else $error("wait_long set on non-wait result");

endmodule

bind spi_flash_erase_program_verify_unit sfepv_checker u_sfepv_checker (.*);

`default_nettype wire
